// File: src/hcbp_pkg.sv
// Shared types and constants for the code bit packer.
`timescale 1ns / 1ps
`default_nettype none

package hcbp_pkg;

    localparam int SYMBOLS      = 256;
    localparam int SYM_W        = 8;
    localparam int IDX_W        = $clog2(SYMBOLS);
    localparam int MAX_CODE_LEN = 32;
    localparam int LEN_W        = 6;
    localparam int CODE_W       = 32;
    localparam int CODE_LEN_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
    localparam int ENTRY_W      = LEN_W + CODE_W;
    localparam int PEND_W       = 7;
    localparam int PCNT_W       = 3;
    localparam int ACC_W        = PEND_W + CODE_W;
    localparam int TOTAL_W      = 6;
    localparam int BYTE_W       = 8;
    localparam int COUNT_W      = 40;
    localparam int MAX_RESULTS  = 4;
    localparam int RCNT_W       = 3;
    localparam int IN_DATA_W    = 48;
    localparam int OUT_DATA_W   = 56;

    localparam logic [COUNT_W-1:0] COUNTER_MAX = {COUNT_W{1'b1}};

    typedef enum logic [1:0] {
        MODE_LOAD   = 2'd0,
        MODE_ENCODE = 2'd1,
        MODE_FLUSH  = 2'd2
    } mode_t;

    typedef struct packed {
        logic              valid;
        logic [1:0]        mode;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } lookup_t;

    typedef struct packed {
        logic [RCNT_W-1:0]                  count;
        logic [MAX_RESULTS-1:0][BYTE_W-1:0] bytes;
        logic                               byte_valid;
        logic [PCNT_W-1:0]                  final_bits;
        logic [COUNT_W-1:0]                 stream_bytes;
    } emit_req_t;

endpackage

`default_nettype wire

// File: src/hcbp_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none

module hcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: src/hcbp_table.sv
// Code table with per-entry valid bits and the lookup stage register.
`timescale 1ns / 1ps
`default_nettype none

module hcbp_table (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       accept,
    input  wire logic [1:0]                 mode,
    input  wire logic [hcbp_pkg::SYM_W-1:0] symbol,
    input  wire logic [hcbp_pkg::LEN_W-1:0] code_length,
    input  wire logic [hcbp_pkg::CODE_W-1:0] code_word,
    input  wire logic                       advance,
    output hcbp_pkg::lookup_t               lookup
);

    import hcbp_pkg::*;

    logic [SYMBOLS-1:0]   vld_reg;
    logic                 stage_valid_reg;
    logic                 stage_valid_next;
    logic [1:0]           mode_reg;
    logic                 hit_reg;
    logic                 in_range;
    logic                 wr_en;
    logic [LEN_W-1:0]     len_clamped;
    logic [ENTRY_W-1:0]   rd_entry;

    assign in_range    = ({1'b0, symbol} < (SYM_W + 1)'(SYMBOLS));
    assign wr_en       = accept && (mode == MODE_LOAD) && in_range;
    assign len_clamped = (code_length > LEN_W'(CODE_LEN_CAP)) ? LEN_W'(CODE_LEN_CAP)
                                                               : code_length;

    always_comb begin
        stage_valid_next = stage_valid_reg;
        if (accept) begin
            stage_valid_next = (mode == MODE_ENCODE) || (mode == MODE_FLUSH);
        end else if (advance) begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg         <= '0;
            stage_valid_reg <= 1'b0;
        end else begin
            stage_valid_reg <= stage_valid_next;
            if (wr_en) begin
                vld_reg[symbol[IDX_W-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg <= mode;
            hit_reg  <= in_range && vld_reg[symbol[IDX_W-1:0]];
        end
    end

    hcbp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SYMBOLS)
    ) u_code_ram (
        .clk   (aclk),
        .we    (wr_en),
        .waddr (symbol[IDX_W-1:0]),
        .wdata ({len_clamped, code_word}),
        .re    (accept),
        .raddr (symbol[IDX_W-1:0]),
        .rdata (rd_entry)
    );

    // An entry never loaded reads as length zero.
    always_comb begin
        lookup.valid = stage_valid_reg;
        lookup.mode  = mode_reg;
        lookup.len   = hit_reg ? rd_entry[ENTRY_W-1:CODE_W] : '0;
        lookup.code  = rd_entry[CODE_W-1:0];
    end

endmodule

`default_nettype wire

// File: src/hcbp_pack.sv
// Bit accumulator: appends code bits, splits full bytes and tracks the byte count.
`timescale 1ns / 1ps
`default_nettype none

module hcbp_pack (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire hcbp_pkg::lookup_t   lookup,
    input  wire logic                emit_free,
    output logic                     advance,
    output hcbp_pkg::emit_req_t      req
);

    import hcbp_pkg::*;

    logic [PEND_W-1:0]  pend_reg;
    logic [PEND_W-1:0]  pend_next;
    logic [PCNT_W-1:0]  pcnt_reg;
    logic [PCNT_W-1:0]  pcnt_next;
    logic [COUNT_W-1:0] bytes_reg;
    logic [COUNT_W-1:0] bytes_next;
    logic [CODE_W-1:0]  code_mask;
    logic [ACC_W-1:0]   acc;
    logic [ACC_W-1:0]   rest;
    logic [TOTAL_W-1:0] total;
    logic [RCNT_W-1:0]  nbytes;
    logic [COUNT_W:0]   enc_sum;
    logic [COUNT_W:0]   one_sum;
    logic [COUNT_W-1:0] enc_count;
    logic [COUNT_W-1:0] one_count;

    assign code_mask = (lookup.len >= LEN_W'(CODE_W)) ? {CODE_W{1'b1}}
                     : ((CODE_W'(1) << lookup.len) - CODE_W'(1));
    assign acc       = ACC_W'(pend_reg) | (ACC_W'(lookup.code & code_mask) << pcnt_reg);
    assign total     = TOTAL_W'(pcnt_reg) + lookup.len;
    assign nbytes    = total[TOTAL_W-1:3];

    assign enc_sum   = {1'b0, bytes_reg} + (COUNT_W + 1)'(nbytes);
    assign one_sum   = {1'b0, bytes_reg} + (COUNT_W + 1)'(1);
    assign enc_count = enc_sum[COUNT_W] ? COUNTER_MAX : enc_sum[COUNT_W-1:0];
    assign one_count = one_sum[COUNT_W] ? COUNTER_MAX : one_sum[COUNT_W-1:0];

    always_comb begin
        case (nbytes)
            3'd1:    rest = acc >> 8;
            3'd2:    rest = acc >> 16;
            3'd3:    rest = acc >> 24;
            3'd4:    rest = acc >> 32;
            default: rest = acc;
        endcase
    end

    always_comb begin
        req.count        = '0;
        req.bytes        = acc[MAX_RESULTS*BYTE_W-1:0];
        req.byte_valid   = 1'b1;
        req.final_bits   = '0;
        req.stream_bytes = '0;
        pend_next        = pend_reg;
        pcnt_next        = pcnt_reg;
        bytes_next       = bytes_reg;
        case (lookup.mode)
            MODE_ENCODE: begin
                req.count  = nbytes;
                pend_next  = rest[PEND_W-1:0];
                pcnt_next  = total[PCNT_W-1:0];
                bytes_next = enc_count;
            end
            MODE_FLUSH: begin
                req.count      = RCNT_W'(1);
                req.bytes      = {{(MAX_RESULTS * BYTE_W - PEND_W){1'b0}}, pend_reg};
                req.byte_valid = (pcnt_reg != '0);
                req.final_bits = pcnt_reg;
                req.stream_bytes = (pcnt_reg != '0) ? one_count : bytes_reg;
                pend_next      = '0;
                pcnt_next      = '0;
                bytes_next     = '0;
            end
            default: begin
                req.count = '0;
            end
        endcase
    end

    assign advance = lookup.valid && ((req.count == '0) || emit_free);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg  <= '0;
            pcnt_reg  <= '0;
            bytes_reg <= '0;
        end else if (advance) begin
            pend_reg  <= pend_next;
            pcnt_reg  <= pcnt_next;
            bytes_reg <= bytes_next;
        end
    end

endmodule

`default_nettype wire

// File: src/hcbp_emit.sv
// Result buffer: holds up to four results of one request and hands them out in order.
`timescale 1ns / 1ps
`default_nettype none

module hcbp_emit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          push,
    input  wire hcbp_pkg::emit_req_t           req,
    output logic                               emit_free,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [hcbp_pkg::BYTE_W-1:0]        out_byte,
    output logic                               byte_valid,
    output logic [hcbp_pkg::PCNT_W-1:0]        final_bits,
    output logic [hcbp_pkg::COUNT_W-1:0]       stream_bytes,
    output logic                               last
);

    import hcbp_pkg::*;

    logic [MAX_RESULTS-1:0][BYTE_W-1:0] byte_reg;
    logic [RCNT_W-1:0]                  cnt_reg;
    logic [RCNT_W-1:0]                  cnt_next;
    logic                               bv_reg;
    logic [PCNT_W-1:0]                  fb_reg;
    logic [COUNT_W-1:0]                 sb_reg;
    logic                               pop;

    assign m_tvalid  = (cnt_reg != '0);
    assign pop       = m_tvalid && m_tready;
    assign emit_free = (cnt_reg == '0) || ((cnt_reg == RCNT_W'(1)) && m_tready);

    always_comb begin
        cnt_next = cnt_reg;
        if (push) begin
            cnt_next = req.count;
        end else if (pop) begin
            cnt_next = cnt_reg - RCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            byte_reg <= req.bytes;
            bv_reg   <= req.byte_valid;
            fb_reg   <= req.final_bits;
            sb_reg   <= req.stream_bytes;
        end else if (pop) begin
            for (int i = 0; i < MAX_RESULTS - 1; i++) begin
                byte_reg[i] <= byte_reg[i+1];
            end
        end
    end

    assign out_byte     = byte_reg[0];
    assign byte_valid   = bv_reg;
    assign final_bits   = fb_reg;
    assign stream_bytes = sb_reg;
    assign last         = (cnt_reg == RCNT_W'(1));

endmodule

`default_nettype wire

// File: src/huffman_code_bit_packer_top.sv
// Top level of the prefix code bit packer: table lookup, bit packing and result buffer.
//
//   Channel  Direction  tdata (low bit up)                          tuser        tlast
//   s_       in         symbol, code_length, code_word              mode         -
//   m_       out        out_byte, final_bits, stream_bytes          byte_valid   last
//
// A request is taken every cycle unless stalled; its first result passes the lookup stage
// and result buffer registers. An encode that completes k bytes (k up to 4) fills the
// buffer with k results; a result-yielding request waits only while that buffer is busy.
// Loads write the code RAM at acceptance and give no result.
// Reset clears the code length valid bits, the bit buffer and the byte counter at once.
`timescale 1ns / 1ps
`default_nettype none

module huffman_code_bit_packer_top (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // symbol[7:0], code_length[13:8], code_word[45:14], zero fill
    input  wire logic [hcbp_pkg::IN_DATA_W-1:0]   s_tdata,
    // mode[1:0]
    input  wire logic [1:0]                       s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // out_byte[7:0], final_bits[10:8], stream_bytes[50:11], zero fill
    output logic [hcbp_pkg::OUT_DATA_W-1:0]       m_tdata,
    // byte_valid[0]
    output logic                                  m_tuser,
    output logic                                  m_tlast
);

    import hcbp_pkg::*;

    lookup_t            lookup;
    emit_req_t          req;
    logic               advance;
    logic               accept;
    logic               emit_free;
    logic               push;
    logic [BYTE_W-1:0]  out_byte;
    logic [PCNT_W-1:0]  final_bits;
    logic [COUNT_W-1:0] stream_bytes;

    assign s_tready = !lookup.valid || advance;
    assign accept   = s_tvalid && s_tready;
    assign push     = advance && (req.count != '0);

    hcbp_table u_table (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .mode        (s_tuser),
        .symbol      (s_tdata[SYM_W-1:0]),
        .code_length (s_tdata[SYM_W+LEN_W-1:SYM_W]),
        .code_word   (s_tdata[SYM_W+LEN_W+CODE_W-1:SYM_W+LEN_W]),
        .advance     (advance),
        .lookup      (lookup)
    );

    hcbp_pack u_pack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .lookup    (lookup),
        .emit_free (emit_free),
        .advance   (advance),
        .req       (req)
    );

    hcbp_emit u_emit (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push         (push),
        .req          (req),
        .emit_free    (emit_free),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .out_byte     (out_byte),
        .byte_valid   (m_tuser),
        .final_bits   (final_bits),
        .stream_bytes (stream_bytes),
        .last         (m_tlast)
    );

    assign m_tdata = {{(OUT_DATA_W - BYTE_W - PCNT_W - COUNT_W){1'b0}},
                      stream_bytes, final_bits, out_byte};

    // Results are only loaded into the buffer when it can take them.
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> emit_free)
        else $error("result buffer overwritten");

    // An empty-flush result is always the single, final result of its request.
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> m_tlast)
        else $error("empty flush result not marked last");

    // Only a flush result carries a byte count or a partial bit count.
    a_enc_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> ((final_bits == '0) && (stream_bytes == '0)))
        else $error("encode result carries flush fields");

    // Input stalls only while a request sits in the lookup stage.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (lookup.valid && (req.count != '0)))
        else $error("input stalled without a blocked request");

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for the prefix code bit packer with randomized stream traffic.
`timescale 1ns / 1ps

module tb_top;
    import hcbp_pkg::*;

    localparam logic [1:0] MODE_RESERVED = 2'd3;
    localparam int         RANDOM_REQS   = 290;
    localparam int         CYCLE_LIMIT   = 200000;
    localparam int         MAX_REPORTS   = 10;

    typedef struct packed {
        logic [1:0]        mode;
        logic [SYM_W-1:0]  symbol;
        logic [LEN_W-1:0]  code_length;
        logic [CODE_W-1:0] code_word;
    } code_req_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic               byte_valid;
        logic [PCNT_W-1:0]  final_bits;
        logic [COUNT_W-1:0] stream_bytes;
        logic               last;
    } packed_byte_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [1:0]            s_tuser  = MODE_LOAD;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    huffman_code_bit_packer_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Packer state mirrored by the testbench.
    logic [LEN_W-1:0]   len_tab [SYMBOLS];
    logic [CODE_W-1:0]  code_tab [SYMBOLS];
    logic [PEND_W-1:0]  pend_bits;
    logic [PCNT_W-1:0]  pend_cnt;
    logic [COUNT_W-1:0] stream_cnt;

    code_req_t    req_q [$];
    packed_byte_t predicted_bytes [$];
    logic [7:0]   loaded_syms [$];
    code_req_t    cur_req;
    int           req_total;
    int           sent_cnt;
    int           errors;
    int           cycle_cnt;

    initial begin
        forever #4 aclk = ~aclk;
    end

    task automatic bump_stream_cnt();
        if (stream_cnt != COUNTER_MAX)
            stream_cnt = stream_cnt + 1'b1;
    endtask

    task automatic pack_request(input code_req_t req);
        packed_byte_t  res;
        int unsigned   len;
        int unsigned   total;
        logic [63:0]   code;
        logic [63:0]   acc;
        case (req.mode)
            MODE_LOAD: begin
                len_tab[req.symbol]  = (req.code_length > CODE_LEN_CAP) ?
                                       LEN_W'(CODE_LEN_CAP) : req.code_length;
                code_tab[req.symbol] = req.code_word;
            end
            MODE_ENCODE: begin
                len = len_tab[req.symbol];
                if (len != 0) begin
                    code = {32'd0, code_tab[req.symbol]};
                    if (len < 32)
                        code = code & ((64'd1 << len) - 64'd1);
                    acc   = {57'd0, pend_bits} | (code << pend_cnt);
                    total = pend_cnt + len;
                    while (total >= 8) begin
                        total = total - 8;
                        res   = '0;
                        res.out_byte   = acc[7:0];
                        res.byte_valid = 1'b1;
                        res.last       = (total < 8);
                        predicted_bytes.push_back(res);
                        bump_stream_cnt();
                        acc = acc >> 8;
                    end
                    pend_bits = acc[PEND_W-1:0];
                    pend_cnt  = total[PCNT_W-1:0];
                end
            end
            MODE_FLUSH: begin
                res = '0;
                if (pend_cnt != 0) begin
                    bump_stream_cnt();
                    res.out_byte   = {1'b0, pend_bits};
                    res.byte_valid = 1'b1;
                    res.final_bits = pend_cnt;
                end
                res.stream_bytes = stream_cnt;
                res.last         = 1'b1;
                predicted_bytes.push_back(res);
                pend_bits  = '0;
                pend_cnt   = '0;
                stream_cnt = '0;
            end
            default: ;
        endcase
    endtask

    task automatic add_req(input logic [1:0] mode, input logic [7:0] sym,
                           input logic [5:0] len, input logic [31:0] word);
        code_req_t req;
        req.mode        = mode;
        req.symbol      = sym;
        req.code_length = len;
        req.code_word   = word;
        req_q.push_back(req);
        if (mode == MODE_LOAD && len != 0)
            loaded_syms.push_back(sym);
    endtask

    function automatic int send_idle_pct();
        case ((sent_cnt * 3) / req_total)
            0:       return 32;
            1:       return 47;
            default: return 0;
        endcase
    endfunction

    function automatic int recv_idle_pct();
        case ((sent_cnt * 3) / req_total)
            0:       return 47;
            1:       return 32;
            default: return 0;
        endcase
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                pack_request(cur_req);
                sent_cnt = sent_cnt + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (req_q.size() > 0 && $urandom_range(99) >= send_idle_pct()) begin
                    cur_req = req_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {2'b00, cur_req.code_word, cur_req.code_length,
                                 cur_req.symbol};
                    s_tuser  <= cur_req.mode;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : result_monitor
        packed_byte_t got;
        packed_byte_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.out_byte     = m_tdata[7:0];
                got.final_bits   = m_tdata[10:8];
                got.stream_bytes = m_tdata[50:11];
                got.byte_valid   = m_tuser;
                got.last         = m_tlast;
                if (predicted_bytes.size() == 0) begin
                    errors = errors + 1;
                    if (errors <= MAX_REPORTS)
                        $display("Unexpected result: byte %h valid %b bits %0d count %0d last %b",
                                 got.out_byte, got.byte_valid, got.final_bits,
                                 got.stream_bytes, got.last);
                end else begin
                    want = predicted_bytes.pop_front();
                    if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
                        got.final_bits !== want.final_bits ||
                        got.stream_bytes !== want.stream_bytes || got.last !== want.last) begin
                        errors = errors + 1;
                        if (errors <= MAX_REPORTS)
                            $display({"Mismatch: expected byte %h valid %b bits %0d count %0d",
                                      " last %b, got byte %h valid %b bits %0d count %0d last %b"},
                                     want.out_byte, want.byte_valid, want.final_bits,
                                     want.stream_bytes, want.last, got.out_byte,
                                     got.byte_valid, got.final_bits, got.stream_bytes,
                                     got.last);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct());
        end
    end

    always @(posedge aclk) begin
        cycle_cnt = cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int          counted;
        int          pick;
        logic [7:0]  sym;
        logic [5:0]  len;
        for (int i = 0; i < SYMBOLS; i++) begin
            len_tab[i]  = '0;
            code_tab[i] = '0;
        end
        pend_bits  = '0;
        pend_cnt   = '0;
        stream_cnt = '0;
        sent_cnt   = 0;
        errors     = 0;
        cycle_cnt  = 0;

        // Directed opening: empty flush, unloaded and zero-length symbols, long codes,
        // saturated lengths, ignored high code bits, reserved mode and byte-aligned flush.
        add_req(MODE_FLUSH,    8'd0,   6'd0,  32'h0000_0000);
        add_req(MODE_ENCODE,   8'd0,   6'd0,  32'h0000_0000);
        add_req(MODE_RESERVED, 8'hFF,  6'h3F, 32'hFFFF_FFFF);
        add_req(MODE_LOAD,     8'd255, 6'd32, 32'hFFFF_FFFF);
        add_req(MODE_LOAD,     8'd0,   6'd1,  32'h0000_0001);
        add_req(MODE_LOAD,     8'd1,   6'd63, 32'hA5A5_5A5A);
        add_req(MODE_LOAD,     8'd2,   6'd7,  32'hFFFF_FFD5);
        add_req(MODE_LOAD,     8'd3,   6'd0,  32'h1234_5678);
        add_req(MODE_LOAD,     8'd4,   6'd32, 32'h0000_0000);
        add_req(MODE_ENCODE,   8'd255, 6'd0,  32'h0000_0000);
        add_req(MODE_ENCODE,   8'd0,   6'h3F, 32'hFFFF_FFFF);
        add_req(MODE_ENCODE,   8'd1,   6'd0,  32'h0000_0000);
        add_req(MODE_ENCODE,   8'd2,   6'd0,  32'h0000_0000);
        add_req(MODE_ENCODE,   8'd3,   6'd0,  32'h0000_0000);
        add_req(MODE_ENCODE,   8'd0,   6'd0,  32'h0000_0000);
        add_req(MODE_FLUSH,    8'd0,   6'd0,  32'h0000_0000);
        add_req(MODE_ENCODE,   8'd4,   6'd0,  32'h0000_0000);
        add_req(MODE_FLUSH,    8'd0,   6'd0,  32'h0000_0000);
        add_req(MODE_LOAD,     8'd128, 6'd5,  32'h0000_001F);
        add_req(MODE_ENCODE,   8'd128, 6'd0,  32'h0000_0000);
        add_req(MODE_ENCODE,   8'd128, 6'd0,  32'h0000_0000);
        add_req(MODE_ENCODE,   8'd2,   6'd0,  32'h0000_0000);
        add_req(MODE_FLUSH,    8'd0,   6'd0,  32'h0000_0000);

        // Random streams: mostly encodes of loaded symbols, with table updates and flushes.
        counted = 0;
        while (counted < RANDOM_REQS) begin
            pick = $urandom_range(99);
            if (pick < 2) begin
                add_req(MODE_RESERVED, 8'($urandom_range(255)), 6'($urandom_range(63)),
                        $urandom);
            end else begin
                counted = counted + 1;
                if (pick < 20) begin
                    sym  = 8'($urandom_range(255));
                    pick = $urandom_range(99);
                    if (pick < 10)
                        len = 6'd0;
                    else if (pick < 70)
                        len = 6'($urandom_range(10, 1));
                    else if (pick < 90)
                        len = 6'($urandom_range(32, 11));
                    else
                        len = 6'($urandom_range(63, 33));
                    add_req(MODE_LOAD, sym, len, $urandom);
                end else if (pick < 27) begin
                    add_req(MODE_FLUSH, 8'($urandom_range(255)), 6'($urandom_range(63)),
                            $urandom);
                end else begin
                    if (loaded_syms.size() > 0 && $urandom_range(99) < 85)
                        sym = loaded_syms[$urandom_range(loaded_syms.size() - 1)];
                    else
                        sym = 8'($urandom_range(255));
                    add_req(MODE_ENCODE, sym, 6'($urandom_range(63)), $urandom);
                end
            end
        end
        add_req(MODE_FLUSH, 8'd0, 6'd0, 32'h0000_0000);
        req_total = req_q.size();

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (req_q.size() != 0 || s_tvalid || predicted_bytes.size() != 0)
            @(posedge aclk);
        repeat (16) @(posedge aclk);

        if (predicted_bytes.size() != 0) begin
            $display("%0d expected results never arrived", predicted_bytes.size());
            errors = errors + predicted_bytes.size();
        end
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: sim.f
src/hcbp_pkg.sv
src/hcbp_ram.sv
src/hcbp_table.sv
src/hcbp_pack.sv
src/hcbp_emit.sv
src/huffman_code_bit_packer_top.sv
tb/tb_top.sv
